// ===== sv/ewma_pkg.sv =====
`timescale 1ns / 1ps

package ewma_pkg;

  // Sample and window geometry.
  localparam int SAMPLE_W = 16;
  localparam int SUM_W    = 24;
  localparam int WINDOW   = 8;

  // Slot index into the sample store and count of samples held.
  localparam int SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int COUNT_W = $clog2(WINDOW + 1);

  // Step counter of the bit-serial divider, one quotient bit per cycle.
  localparam int STEP_W = $clog2(SUM_W);

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_DIVIDE = 5'b00100,
    ST_DONE   = 5'b01000,
    ST_HOLD   = 5'b10000
  } state_e;

endpackage

// ===== sv/ewma_in_if.sv =====
`timescale 1ns / 1ps

interface ewma_in_if;
  logic                           valid;
  logic                           ready;
  logic [ewma_pkg::SAMPLE_W-1:0] pulse_width;

  modport source (output valid, output pulse_width, input ready);
  modport sink   (input valid, input pulse_width, output ready);
endinterface

// ===== sv/ewma_out_if.sv =====
`timescale 1ns / 1ps

interface ewma_out_if;
  logic                           valid;
  logic                           ready;
  logic                           timed_out;
  logic [ewma_pkg::SAMPLE_W-1:0] raw_width;
  logic [ewma_pkg::SAMPLE_W-1:0] mean_width;

  modport source (output valid, output timed_out, output raw_width, output mean_width,
                  input ready);
  modport sink   (input valid, input timed_out, input raw_width, input mean_width,
                  output ready);
endinterface

// ===== sv/ewma_ram.sv =====
`timescale 1ns / 1ps

module ewma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/echo_width_moving_average.sv =====
`timescale 1ns / 1ps
// A valid width goes through the sequencer in order: ST_UPDATE updates the running sum and
// the sample store, ST_DIVIDE runs the bit-serial divider, and ST_DONE loads the output
// register once it is free, so a result can stall there while out_o.ready is low.
// A timeout beat skips the update and the divider and goes straight to ST_DONE.
// A new beat is accepted only in ST_IDLE, so no new beat is taken until the last has left ST_HOLD.
// Reset clears the sum, fill state, held values and handshake state at once.

module echo_width_moving_average (
  input  logic      clk_i,
  input  logic      rst_ni,
  ewma_in_if.sink   in_i,
  ewma_out_if.source out_o
);

  import ewma_pkg::*;

  state_e               state_q, state_d;
  logic [SAMPLE_W-1:0]  sample_q;
  logic [SLOT_W-1:0]    slot_q;
  logic                 full_q;
  logic [SUM_W-1:0]     sum_q, sum_d;
  logic [SAMPLE_W-1:0]  held_raw_q;
  logic [SAMPLE_W-1:0]  held_mean_q;
  logic                 flag_q;

  // Divider registers: the quotient shifts in where the dividend shifts out.
  logic [SUM_W-1:0]     quot_q, quot_d;
  logic [COUNT_W-1:0]   rem_q, rem_d;
  logic [COUNT_W-1:0]   div_q;
  logic [STEP_W-1:0]    step_q;

  // Output register.
  logic                 out_valid_q;
  logic                 out_flag_q;
  logic [SAMPLE_W-1:0]  out_raw_q;
  logic [SAMPLE_W-1:0]  out_mean_q;

  logic                 in_beat;
  logic                 out_free;
  logic [SAMPLE_W-1:0]  ram_rdata;
  logic [SAMPLE_W-1:0]  evicted;
  logic                 slot_wrap;
  logic [COUNT_W-1:0]   count_next;
  logic [COUNT_W:0]     trial;
  logic                 last_step;

  assign in_beat  = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign out_free = !out_valid_q || out_o.ready;

  // Sample store, read at the write slot on acceptance to find the evicted sample.
  ewma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_UPDATE),
    .waddr_i (slot_q),
    .wdata_i (sample_q),
    .re_i    (in_beat),
    .raddr_i (slot_q),
    .rdata_o (ram_rdata)
  );

  // Slots not yet filled since reset count as zero.
  assign evicted    = full_q ? ram_rdata : '0;
  assign slot_wrap  = (slot_q == SLOT_W'(WINDOW - 1));
  assign count_next = COUNT_W'(slot_q) + COUNT_W'(1);
  assign sum_d      = sum_q + SUM_W'(sample_q) - SUM_W'(evicted);

  // One restoring division step.
  assign trial     = {rem_q, quot_q[SUM_W-1]} - {1'b0, div_q};
  assign last_step = (step_q == STEP_W'(SUM_W - 1));

  always_comb begin
    if (!trial[COUNT_W]) begin
      rem_d  = trial[COUNT_W-1:0];
      quot_d = {quot_q[SUM_W-2:0], 1'b1};
    end else begin
      rem_d  = {rem_q[COUNT_W-2:0], quot_q[SUM_W-1]};
      quot_d = {quot_q[SUM_W-2:0], 1'b0};
    end
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_beat) begin
          state_d = (in_i.pulse_width == '0) ? ST_DONE : ST_UPDATE;
        end
      end
      ST_UPDATE: state_d = ST_DIVIDE;
      ST_DIVIDE: begin
        if (last_step) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD:  state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Control state and held values.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      slot_q      <= '0;
      full_q      <= 1'b0;
      sum_q       <= '0;
      held_raw_q  <= '0;
      held_mean_q <= '0;
      flag_q      <= 1'b0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_beat) begin
        flag_q <= (in_i.pulse_width == '0);
        if (in_i.pulse_width != '0) begin
          held_raw_q <= in_i.pulse_width;
        end
      end
      if (state_q == ST_UPDATE) begin
        sum_q  <= sum_d;
        slot_q <= slot_wrap ? '0 : slot_q + SLOT_W'(1);
        full_q <= full_q || slot_wrap;
        step_q <= '0;
      end
      if (state_q == ST_DIVIDE) begin
        step_q <= step_q + STEP_W'(1);
        if (last_step) begin
          held_mean_q <= quot_d[SAMPLE_W-1:0];
        end
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Divider and output payload registers.
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      sample_q <= in_i.pulse_width;
    end
    if (state_q == ST_UPDATE) begin
      quot_q <= sum_d;
      rem_q  <= '0;
      div_q  <= (full_q || slot_wrap) ? COUNT_W'(WINDOW) : count_next;
    end else if (state_q == ST_DIVIDE) begin
      quot_q <= quot_d;
      rem_q  <= rem_d;
    end
    if (state_q == ST_DONE && out_free) begin
      out_flag_q <= flag_q;
      out_raw_q  <= held_raw_q;
      out_mean_q <= held_mean_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.timed_out  = out_flag_q;
  assign out_o.raw_width  = out_raw_q;
  assign out_o.mean_width = out_mean_q;

  // A timeout beat skips the update and the divider.
  a_timeout_skips: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_beat && (in_i.pulse_width == '0) |=> (state_q == ST_DONE) && flag_q)
    else $error("timeout beat did not go straight to result");

  // The divider finishes after its last step; it runs SUM_W steps in all.
  a_divide_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) && last_step |=> (state_q == ST_DONE))
    else $error("divider did not finish after its last step");

  // A valid-width result always carries a nonzero raw width.
  a_raw_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.timed_out |-> (out_o.raw_width != '0))
    else $error("valid-width result with zero raw width");

  // The divisor never exceeds the window and is never zero while dividing.
  a_divisor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIVIDE) |-> (div_q != '0) && (div_q <= COUNT_W'(WINDOW)))
    else $error("divisor out of range");

endmodule
